[rtl/core/register_alu_branch_execute_core_defines.svh]
// Assertion macros for the register ALU and branch execute core.
// Needs clk and arst_n in the scope of the including module.
`ifndef REGISTER_ALU_BRANCH_EXECUTE_CORE_DEFINES_SVH
`define REGISTER_ALU_BRANCH_EXECUTE_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RABE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define RABE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rabe_pkg.sv]
// Shared types and codes for the register ALU and branch execute core.
// No dependencies.
package rabe_pkg;

	typedef logic [31:0] data_t;
	typedef logic [4:0]  opcode_t;
	typedef logic [1:0]  status_t;

	localparam int IN_W  = 48;
	localparam int OUT_W = 72;

	localparam opcode_t OP_LOAD  = 5'd0;
	localparam opcode_t OP_MOVE  = 5'd1;
	localparam opcode_t OP_ADD   = 5'd2;
	localparam opcode_t OP_SUB   = 5'd3;
	localparam opcode_t OP_MUL   = 5'd4;
	localparam opcode_t OP_MOD   = 5'd5;
	localparam opcode_t OP_DIV   = 5'd6;
	localparam opcode_t OP_INC   = 5'd7;
	localparam opcode_t OP_DEC   = 5'd8;
	localparam opcode_t OP_EQ    = 5'd9;
	localparam opcode_t OP_GE    = 5'd10;
	localparam opcode_t OP_LE    = 5'd11;
	localparam opcode_t OP_GOTO  = 5'd12;
	localparam opcode_t OP_JZ    = 5'd13;
	localparam opcode_t OP_JNZ   = 5'd14;
	localparam opcode_t OP_SHIFT = 5'd15;
	localparam opcode_t OP_NOP   = 5'd16;
	localparam opcode_t OP_HALT  = 5'd17;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_DIV0 = 2'd1;
	localparam status_t ST_HALT = 2'd2;

endpackage

[rtl/core/register_alu_branch_execute_core.sv]
// Executes one decoded register instruction per input word against NUM_REGS
// registers, with register 0 as the accumulator. Load, move, add, subtract,
// increment, decrement, compare, shift and jump words pass from acceptance to
// the next acceptance through accept, register read, execute and write
// back. Multiply, divide and modulo add an iteration state: a single 34-bit adder is
// stepped 32 times by the sequencer, one multiplier or quotient bit a cycle.
// A divide or modulo by zero skips the iteration and writes nothing. The result
// word sits in an output register; the core accepts the next input while it
// waits, and stalls in write back only if the previous result is still held.
// Depends on rabe_pkg and register_alu_branch_execute_core_defines.svh.
`include "register_alu_branch_execute_core_defines.svh"

module register_alu_branch_execute_core #(
	parameter int NUM_REGS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// req_type[4:0], first_reg[7:5], second_reg[10:8], immediate[42:11], zero[47:43]
	input  logic [rabe_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// wrote[0], dest_index[3:1], dest_value[35:4], redirect[36],
	// next_pointer[68:37], status[70:69], zero[71]
	output logic [rabe_pkg::OUT_W-1:0]   m_axis_tdata
);
	import rabe_pkg::*;

	localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_ITER = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [4:0]          cnt_q;
	logic [NUM_REGS-1:0] vld_q;
	data_t               ip_q;
	data_t               regs_mem [NUM_REGS];

	opcode_t op_q;
	logic [2:0] r1_q, r2_q;
	data_t imm_q;
	data_t rd_a_q, rd_b_q;
	logic a_ok_q, b_ok_q;
	data_t acc_q, opnd_q, base_q;
	logic neg_a_q, neg_b_q;
	logic wr_q, redir_q;
	logic [2:0] dst_q;
	data_t val_q, tgt_q;
	status_t st_q;

	logic accept, fin_go, iter_last, goes_iter;
	logic [2:0] addr_a;
	data_t a_op, b_op, mag_a, mag_b, sh_n, sh_res;
	logic [33:0] add_x, add_y, sum;
	logic add_sub;
	logic [32:0] dv_shift;
	data_t acc_n, opnd_n, div_res, np;
	logic wr_ok;
	logic exec_wr, exec_redir;
	logic [2:0] exec_dst;
	data_t exec_val, exec_tgt;
	status_t exec_st;

	function automatic logic idx_ok(input logic [2:0] idx);
		return {2'b00, idx} < 5'(NUM_REGS);
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fin_go        = (state_q == S_FIN) && (!m_axis_tvalid || m_axis_tready);
	assign iter_last     = (cnt_q == 5'd31);
	assign addr_a        = (op_q == OP_JZ || op_q == OP_JNZ) ? 3'd0 : r1_q;

	assign a_op  = a_ok_q ? rd_a_q : '0;
	assign b_op  = b_ok_q ? rd_b_q : '0;
	assign mag_a = a_op[31] ? (32'd0 - a_op) : a_op;
	assign mag_b = b_op[31] ? (32'd0 - b_op) : b_op;
	assign goes_iter = (op_q == OP_MUL) ||
		((op_q == OP_DIV || op_q == OP_MOD) && (b_op != '0));

	assign sh_n = imm_q[31] ? (32'd0 - imm_q) : imm_q;
	always_comb begin
		if (imm_q[31]) begin
			sh_res = (|sh_n[31:5]) ? '0 : (a_op << sh_n[4:0]);
		end else begin
			sh_res = (|sh_n[31:5]) ? {32{a_op[31]}} : 32'($signed(a_op) >>> sh_n[4:0]);
		end
	end

	// shared adder
	assign dv_shift = {acc_q, opnd_q[31]};
	always_comb begin
		add_x   = {{2{a_op[31]}}, a_op};
		add_y   = {{2{b_op[31]}}, b_op};
		add_sub = 1'b0;
		if (state_q == S_ITER) begin
			if (op_q == OP_MUL) begin
				add_x = {2'b00, acc_q};
				add_y = {2'b00, base_q};
			end else begin
				add_x   = {1'b0, dv_shift};
				add_y   = {2'b00, base_q};
				add_sub = 1'b1;
			end
		end else begin
			case (op_q)
				OP_SUB, OP_EQ, OP_GE, OP_LE: add_sub = 1'b1;
				OP_INC: add_y = 34'd1;
				OP_DEC: begin
					add_y   = 34'd1;
					add_sub = 1'b1;
				end
				default: ;
			endcase
		end
	end
	assign sum = add_x + (add_sub ? ~add_y : add_y) + 34'(add_sub);

	always_comb begin
		if (op_q == OP_MUL) begin
			acc_n  = opnd_q[0] ? sum[31:0] : acc_q;
			opnd_n = {1'b0, opnd_q[31:1]};
		end else begin
			acc_n  = sum[33] ? dv_shift[31:0] : sum[31:0];
			opnd_n = {opnd_q[30:0], ~sum[33]};
		end
		if (op_q == OP_MUL) begin
			div_res = acc_n;
		end else if (op_q == OP_DIV) begin
			div_res = (neg_a_q != neg_b_q) ? (32'd0 - opnd_n) : opnd_n;
		end else begin
			div_res = neg_a_q ? (32'd0 - acc_n) : acc_n;
		end
	end

	// single-step decode
	always_comb begin
		exec_wr    = 1'b0;
		exec_dst   = '0;
		exec_val   = '0;
		exec_redir = 1'b0;
		exec_tgt   = '0;
		exec_st    = ST_OK;
		case (op_q)
			OP_LOAD: begin
				exec_wr  = 1'b1;
				exec_dst = r1_q;
				exec_val = imm_q;
			end
			OP_MOVE: begin
				exec_wr  = 1'b1;
				exec_dst = r1_q;
				exec_val = b_op;
			end
			OP_ADD, OP_SUB: begin
				exec_wr  = 1'b1;
				exec_val = sum[31:0];
			end
			OP_INC, OP_DEC: begin
				exec_wr  = 1'b1;
				exec_dst = r1_q;
				exec_val = sum[31:0];
			end
			OP_EQ: begin
				exec_wr  = 1'b1;
				exec_val = {31'd0, sum == '0};
			end
			OP_GE: begin
				exec_wr  = 1'b1;
				exec_val = {31'd0, ~sum[33]};
			end
			OP_LE: begin
				exec_wr  = 1'b1;
				exec_val = {31'd0, sum[33] || (sum == '0)};
			end
			OP_MOD, OP_DIV: begin
				if (b_op == '0) begin
					exec_st = ST_DIV0;
				end
			end
			OP_GOTO: begin
				exec_redir = 1'b1;
				exec_tgt   = a_op;
			end
			OP_JZ: begin
				exec_redir = (a_op == '0);
				exec_tgt   = imm_q;
			end
			OP_JNZ: begin
				exec_redir = (a_op != '0);
				exec_tgt   = imm_q;
			end
			OP_SHIFT: begin
				exec_wr  = (imm_q != '0);
				exec_dst = r1_q;
				exec_val = sh_res;
			end
			OP_HALT: exec_st = ST_HALT;
			default: ;
		endcase
	end

	assign wr_ok = wr_q && idx_ok(dst_q);
	assign np    = redir_q ? tgt_q : ip_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			vld_q         <= '0;
			ip_q          <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (fin_go) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: state_q <= goes_iter ? S_ITER : S_FIN;
				S_ITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (iter_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						ip_q <= np;
						if (wr_ok) begin
							vld_q[IW'(dst_q)] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// register file
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_a_q <= regs_mem[IW'(addr_a)];
			rd_b_q <= regs_mem[IW'(r2_q)];
			a_ok_q <= idx_ok(addr_a) && vld_q[IW'(addr_a)];
			b_ok_q <= idx_ok(r2_q) && vld_q[IW'(r2_q)];
		end
		if (fin_go && wr_ok) begin
			regs_mem[IW'(dst_q)] <= val_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= s_axis_tdata[4:0];
					r1_q  <= s_axis_tdata[7:5];
					r2_q  <= s_axis_tdata[10:8];
					imm_q <= s_axis_tdata[42:11];
				end
			end
			S_READ: ;
			S_EXEC: begin
				wr_q    <= exec_wr;
				dst_q   <= exec_dst;
				val_q   <= exec_val;
				redir_q <= exec_redir;
				tgt_q   <= exec_tgt;
				st_q    <= exec_st;
				case (op_q)
					OP_MUL: begin
						acc_q  <= '0;
						base_q <= a_op;
						opnd_q <= b_op;
					end
					OP_MOD, OP_DIV: begin
						if (b_op != '0) begin
							acc_q   <= '0;
							opnd_q  <= mag_a;
							base_q  <= mag_b;
							neg_a_q <= a_op[31];
							neg_b_q <= b_op[31];
						end
					end
					default: ;
				endcase
			end
			S_ITER: begin
				acc_q  <= acc_n;
				opnd_q <= opnd_n;
				if (op_q == OP_MUL) begin
					base_q <= {base_q[30:0], 1'b0};
				end
				if (iter_last) begin
					wr_q  <= 1'b1;
					val_q <= div_res;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					m_axis_tdata <= {1'b0, st_q, np, redir_q,
						wr_ok ? val_q : 32'd0, wr_ok ? dst_q : 3'd0, wr_ok};
				end
			end
			default: ;
		endcase
	end

	`RABE_ASSERT_NXT(a_accept_reads, accept, state_q == S_READ, "accepted word did not start a read")
	`RABE_ASSERT_IMP(a_cnt_idle, state_q != S_ITER, cnt_q == 5'd0, "step counter live outside iteration")
	`RABE_ASSERT_IMP(a_div0_nowrite, m_axis_tvalid && m_axis_tdata[70:69] == ST_DIV0, !m_axis_tdata[0], "division by zero wrote a register")
	`RABE_ASSERT_IMP(a_wr_range, m_axis_tvalid && m_axis_tdata[0], idx_ok(m_axis_tdata[3:1]), "write reported beyond register file")

endmodule

[tb/register_alu_branch_execute_core_tb.sv]
// Testbench for register_alu_branch_execute_core: streams decoded instructions in,
// predicts each result word from its own register file and pointer, and checks them.
// Depends on rabe_pkg and register_alu_branch_execute_core.
module register_alu_branch_execute_core_tb;
	import rabe_pkg::*;

	localparam int NUM_REGS    = 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 60;

	typedef struct {
		logic       wrote;
		logic [2:0] dest_index;
		data_t      dest_value;
		logic       redirect;
		data_t      next_pointer;
		status_t    status;
	} exec_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;

	data_t              model_regs [NUM_REGS];
	data_t              model_pointer;
	exec_result_t       pending_results [$];
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 burst_left = 0;
	int                 ready_left = 0;
	int                 ready_mode = 0;
	data_t              corner_vals [5] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF};

	register_alu_branch_execute_core #(
		.NUM_REGS(NUM_REGS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic exec_result_t execute_word(opcode_t op, logic [2:0] r1, logic [2:0] r2,
		data_t imm);
		exec_result_t res;
		data_t        a;
		data_t        b;
		data_t        val;
		data_t        ma;
		data_t        mb;
		data_t        quot;
		data_t        rem;
		data_t        count;
		logic         do_write;
		logic         wrote;
		logic [2:0]   didx;
		a = (r1 < NUM_REGS) ? model_regs[r1] : '0;
		b = (r2 < NUM_REGS) ? model_regs[r2] : '0;
		val = '0;
		didx = '0;
		do_write = 1'b0;
		wrote = 1'b0;
		res.redirect = 1'b0;
		res.status = ST_OK;
		case (op)
			OP_LOAD: begin
				do_write = 1'b1; didx = r1; val = imm;
			end
			OP_MOVE: begin
				do_write = 1'b1; didx = r1; val = b;
			end
			OP_ADD: begin
				do_write = 1'b1; val = a + b;
			end
			OP_SUB: begin
				do_write = 1'b1; val = a - b;
			end
			OP_MUL: begin
				do_write = 1'b1; val = a * b;
			end
			OP_MOD, OP_DIV: begin
				if (b == '0) begin
					res.status = ST_DIV0;
				end else begin
					ma = a[31] ? 32'd0 - a : a;
					mb = b[31] ? 32'd0 - b : b;
					quot = ma / mb;
					rem = ma % mb;
					do_write = 1'b1;
					if (op == OP_DIV)
						val = (a[31] != b[31]) ? 32'd0 - quot : quot;
					else
						val = a[31] ? 32'd0 - rem : rem;
				end
			end
			OP_INC: begin
				do_write = 1'b1; didx = r1; val = a + 32'd1;
			end
			OP_DEC: begin
				do_write = 1'b1; didx = r1; val = a - 32'd1;
			end
			OP_EQ: begin
				do_write = 1'b1; val = (a == b) ? 32'd1 : 32'd0;
			end
			OP_GE: begin
				do_write = 1'b1; val = ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
			end
			OP_LE: begin
				do_write = 1'b1; val = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
			end
			OP_GOTO: begin
				res.redirect = 1'b1; model_pointer = a;
			end
			OP_JZ: begin
				if (model_regs[0] == '0) begin
					res.redirect = 1'b1; model_pointer = imm;
				end
			end
			OP_JNZ: begin
				if (model_regs[0] != '0) begin
					res.redirect = 1'b1; model_pointer = imm;
				end
			end
			OP_SHIFT: begin
				if (imm != '0) begin
					count = imm[31] ? 32'd0 - imm : imm;
					do_write = 1'b1;
					didx = r1;
					if (imm[31])
						val = (count >= 32) ? 32'd0 : a << count;
					else
						val = (count >= 32) ? {32{a[31]}} : data_t'($signed(a) >>> count);
				end
			end
			OP_HALT: begin
				res.status = ST_HALT;
			end
			default: begin
			end
		endcase
		if (do_write && didx < NUM_REGS) begin
			model_regs[didx] = val;
			wrote = 1'b1;
		end
		res.wrote = wrote;
		res.dest_index = wrote ? didx : 3'd0;
		res.dest_value = wrote ? val : '0;
		res.next_pointer = model_pointer;
		return res;
	endfunction

	task automatic issue_word(opcode_t op, logic [2:0] r1, logic [2:0] r2, data_t imm);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tdata <= {5'b0, imm, r2, r1, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(execute_word(op, r1, r2, imm));
		burst_left--;
	endtask

	task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	task automatic check_result(logic [OUT_W-1:0] word);
		exec_result_t exp_res;
		if (pending_results.size() == 0) begin
			$error("unexpected result word 0x%018h", word);
			mismatch_count++;
		end else begin
			exp_res = pending_results.pop_front();
			compare_field("wrote", 32'(exp_res.wrote), 32'(word[0]));
			compare_field("dest_index", 32'(exp_res.dest_index), 32'(word[3:1]));
			compare_field("dest_value", exp_res.dest_value, word[35:4]);
			compare_field("redirect", 32'(exp_res.redirect), 32'(word[36]));
			compare_field("next_pointer", exp_res.next_pointer, word[68:37]);
			compare_field("status", 32'(exp_res.status), 32'(word[70:69]));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata);
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(16, 160);
		end
		ready_left--;
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("register_alu_branch_execute_core verification failed");
			$finish;
		end
	end

	task automatic test_arithmetic();
		issue_word(OP_LOAD, 3'd0, 3'd0, 32'h7FFF_FFFF);
		issue_word(OP_LOAD, 3'd1, 3'd0, 32'h8000_0000);
		issue_word(OP_LOAD, 3'd7, 3'd0, 32'hFFFF_FFFF);
		issue_word(OP_ADD, 3'd0, 3'd1, 32'h0);
		issue_word(OP_SUB, 3'd1, 3'd7, 32'h0);
		issue_word(OP_MUL, 3'd7, 3'd7, 32'h0);
		issue_word(OP_MOVE, 3'd2, 3'd1, 32'h0);
		issue_word(OP_DEC, 3'd1, 3'd0, 32'h0);
		issue_word(OP_INC, 3'd1, 3'd0, 32'h0);
	endtask

	task automatic test_division();
		issue_word(OP_DIV, 3'd1, 3'd7, 32'h0);
		issue_word(OP_MOD, 3'd1, 3'd7, 32'h0);
		issue_word(OP_LOAD, 3'd3, 3'd0, 32'hFFFF_FFF9);
		issue_word(OP_LOAD, 3'd4, 3'd0, 32'd2);
		issue_word(OP_DIV, 3'd3, 3'd4, 32'h0);
		issue_word(OP_MOD, 3'd3, 3'd4, 32'h0);
		issue_word(OP_DIV, 3'd3, 3'd5, 32'h0);
		issue_word(OP_MOD, 3'd4, 3'd5, 32'h0);
	endtask

	task automatic test_compare_shift();
		issue_word(OP_EQ, 3'd3, 3'd3, 32'h0);
		issue_word(OP_GE, 3'd1, 3'd7, 32'h0);
		issue_word(OP_LE, 3'd1, 3'd7, 32'h0);
		issue_word(OP_SHIFT, 3'd3, 3'd0, 32'd1);
		issue_word(OP_SHIFT, 3'd7, 3'd0, 32'hFFFF_FFE1);
		issue_word(OP_SHIFT, 3'd3, 3'd0, 32'd40);
		issue_word(OP_SHIFT, 3'd4, 3'd0, 32'h8000_0000);
		issue_word(OP_SHIFT, 3'd4, 3'd0, 32'h0);
	endtask

	task automatic test_branches();
		issue_word(OP_JZ, 3'd0, 3'd0, 32'h1234_5678);
		issue_word(OP_JNZ, 3'd0, 3'd0, 32'hFFFF_FFFF);
		issue_word(OP_GOTO, 3'd1, 3'd0, 32'h0);
		issue_word(OP_LOAD, 3'd0, 3'd0, 32'h0);
		issue_word(OP_JZ, 3'd0, 3'd0, 32'hDEAD_BEEF);
		issue_word(OP_JNZ, 3'd0, 3'd0, 32'h0000_0040);
		issue_word(OP_HALT, 3'd7, 3'd7, 32'hFFFF_FFFF);
		issue_word(OP_NOP, 3'd2, 3'd5, 32'h5555_5555);
		issue_word(opcode_t'(5'd31), 3'd0, 3'd0, 32'hAAAA_AAAA);
	endtask

	task automatic test_random_program(int count);
		opcode_t op;
		data_t   imm;
		repeat (count) begin
			if ($urandom_range(0, 19) == 0)
				op = opcode_t'($urandom_range(18, 31));
			else
				op = opcode_t'($urandom_range(0, 17));
			case ($urandom_range(0, 3))
				0: imm = corner_vals[$urandom_range(0, 4)];
				1: imm = $urandom_range(0, 80) - 40;
				default: imm = $urandom;
			endcase
			issue_word(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), imm);
		end
	endtask

	initial begin
		foreach (model_regs[i])
			model_regs[i] = '0;
		model_pointer = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arithmetic();
		test_division();
		test_compare_shift();
		test_branches();
		test_random_program(416);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("register_alu_branch_execute_core verification clean");
		else
			$display("register_alu_branch_execute_core verification failed");
		$finish;
	end
endmodule
